// ----- rtl/xalu_pkg.sv -----
// Shared types, operation codes and width helpers for the x86 integer ALU.
`default_nettype none

package xalu_pkg;

	// Operation codes
	localparam logic [3:0] KIND_ADD   = 4'd0;
	localparam logic [3:0] KIND_ADC   = 4'd1;
	localparam logic [3:0] KIND_SUB   = 4'd2;
	localparam logic [3:0] KIND_SBB   = 4'd3;
	localparam logic [3:0] KIND_CMP   = 4'd4;
	localparam logic [3:0] KIND_INC   = 4'd5;
	localparam logic [3:0] KIND_DEC   = 4'd6;
	localparam logic [3:0] KIND_NEG   = 4'd7;
	localparam logic [3:0] KIND_MUL   = 4'd8;
	localparam logic [3:0] KIND_IMULW = 4'd9;
	localparam logic [3:0] KIND_IMULT = 4'd10;
	localparam logic [3:0] KIND_DIV   = 4'd11;
	localparam logic [3:0] KIND_IDIV  = 4'd12;

	// Operand width codes
	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_WORD  = 2'd1;
	localparam logic [1:0] SIZE_DWORD = 2'd2;

	// Flag mask values
	localparam logic [3:0] FW_ALL   = 4'd15;
	localparam logic [3:0] FW_NO_CF = 4'd14;
	localparam logic [3:0] FW_CF_OF = 4'd3;

	// One quotient bit per divider stage
	localparam int DIV_STEPS = 32;

	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  size_code;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic        carry_in;
		logic [31:0] acc_low;
		logic [31:0] acc_high;
	} in_t;

	typedef struct packed {
		logic [31:0] result_low;
		logic [31:0] result_high;
		logic        write_result;
		logic        carry_flag;
		logic        overflow_flag;
		logic        zero_flag;
		logic        sign_flag;
		logic [3:0]  flags_written;
		logic        divide_error;
	} out_t;

	// Word carried down the pipeline
	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  size_code;
		logic        nneg;
		logic        dneg;
		logic        de;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] dm;
		logic        cf;
		logic        of;
		logic        zf;
		logic        sf;
	} pipe_t;

	function automatic logic [31:0] width_mask(input logic [1:0] sz);
		case (sz)
			SIZE_BYTE: width_mask = 32'h0000_00ff;
			SIZE_WORD: width_mask = 32'h0000_ffff;
			default:   width_mask = 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [31:0] sign_bit(input logic [1:0] sz);
		case (sz)
			SIZE_BYTE: sign_bit = 32'h0000_0080;
			SIZE_WORD: sign_bit = 32'h0000_8000;
			default:   sign_bit = 32'h8000_0000;
		endcase
	endfunction

	// Sign-extend a masked value to 32 bits
	function automatic logic [31:0] sext32(input logic [31:0] v, input logic [31:0] sb);
		sext32 = (v ^ sb) - sb;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/x86_integer_alu_with_flags_core.sv -----
// Top level of the pipelined x86 integer ALU with flags.
//
// Input channel in_valid/in_ready/in_data carries one operation word: kind,
// operand width, operands, carry in and the accumulator pair. Output channel
// out_valid/out_ready/out_data returns one result word per input word, in
// order: low result, high half or remainder, write enable, CF/OF/ZF/SF with
// their written mask, and divide_error.
// Every word, whatever its kind, goes through the same 34 register stages:
// one decode stage (add/sub group, multiplier and divider setup), 32
// restoring divider stages that each produce one quotient bit, and the
// final output register. One word is taken per cycle while the receiver
// does not stall.
// Reset clears every stage's valid bit; the pipeline starts empty.
// When the receiver stalls with a result pending, all stages hold together
// and in_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module x86_integer_alu_with_flags_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire xalu_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output xalu_pkg::out_t      out_data
);
	import xalu_pkg::*;

	logic                  adv;
	logic [DIV_STEPS:0]    vld;
	xalu_pkg::pipe_t       st [DIV_STEPS+1];

	// Advance all stages unless a result waits and is not taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	xalu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.vld_s1   (vld[0]),
		.st_s1    (st[0])
	);

	// Divider chain
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		xalu_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (vld[k]),
			.st_i   (st[k]),
			.vld_s1 (vld[k+1]),
			.st_s1  (st[k+1])
		);
	end

	xalu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_i     (vld[DIV_STEPS]),
		.st_i      (st[DIV_STEPS]),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// A divide error never writes the destination or flags
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_error |->
			!out_data.write_result && out_data.flags_written == 4'd0)
		else $error("divide error with write or flags");

	// Multiply results never report ZF or SF
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.flags_written == FW_CF_OF |->
			!out_data.zero_flag && !out_data.sign_flag)
		else $error("multiply reported ZF or SF");

	// An accepted word enters the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld[0])
		else $error("accepted word dropped");

	// A stall freezes every stage
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld) && out_valid)
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ----- rtl/xalu_front.sv -----
// Decode stage: add/sub group, multiplier and divider setup.
`default_nettype none

module xalu_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  wire                  in_valid,
	input  wire xalu_pkg::in_t   in_data,
	output logic                 vld_s1,
	output xalu_pkg::pipe_t      st_s1
);
	import xalu_pkg::*;

	xalu_pkg::pipe_t nx;

	// Compute all per-kind values for the incoming word
	always_comb begin
		logic [31:0] m, sb, a, b, bb, r, accm, xs, as32, ds32, dm;
		logic        c, nneg, dneg;
		logic [32:0] s33, d33, x33, y33;
		logic [63:0] n, ns, nm, nsh;
		logic signed [65:0] prod;
		m    = width_mask(in_data.size_code);
		sb   = sign_bit(in_data.size_code);
		a    = in_data.operand_a & m;
		b    = in_data.operand_b & m;
		accm = in_data.acc_low & m;
		bb   = (in_data.kind == KIND_INC || in_data.kind == KIND_DEC) ? 32'd1 : b;
		c    = (in_data.kind == KIND_ADC || in_data.kind == KIND_SBB) ? in_data.carry_in : 1'b0;
		s33  = {1'b0, a} + {1'b0, bb} + {32'd0, c};
		d33  = {1'b0, a} - {1'b0, bb} - {32'd0, c};

		// Multiplier: zero-extend for mul, sign-extend for imul
		xs   = sext32((in_data.kind == KIND_IMULW) ? accm : b, sb);
		as32 = sext32(a, sb);
		x33  = (in_data.kind == KIND_MUL) ? {1'b0, accm} : {xs[31], xs};
		y33  = (in_data.kind == KIND_MUL) ? {1'b0, a} : {as32[31], as32};
		prod = $signed(x33) * $signed(y33);

		// Dividend and divisor magnitudes
		case (in_data.size_code)
			SIZE_BYTE: begin
				n  = {48'd0, in_data.acc_low[15:0]};
				ns = {{48{n[15]}}, n[15:0]};
			end
			SIZE_WORD: begin
				n  = {32'd0, in_data.acc_high[15:0], in_data.acc_low[15:0]};
				ns = {{32{n[31]}}, n[31:0]};
			end
			default: begin
				n  = {in_data.acc_high, in_data.acc_low};
				ns = n;
			end
		endcase
		ds32 = sext32(a, sb);
		if (in_data.kind == KIND_IDIV) begin
			nneg = ns[63];
			dneg = ds32[31];
			nm   = nneg ? (64'd0 - ns) : ns;
			dm   = dneg ? (32'd0 - ds32) : ds32;
		end else begin
			nneg = 1'b0;
			dneg = 1'b0;
			nm   = n;
			dm   = a;
		end
		case (in_data.size_code)
			SIZE_BYTE: nsh = nm >> 8;
			SIZE_WORD: nsh = nm >> 16;
			default:   nsh = nm >> 32;
		endcase

		nx           = '0;
		nx.kind      = in_data.kind;
		nx.size_code = in_data.size_code;
		r            = 32'd0;
		case (in_data.kind)
			KIND_ADD, KIND_ADC, KIND_INC: begin
				r     = s33[31:0] & m;
				nx.lo = r;
				case (in_data.size_code)
					SIZE_BYTE: nx.cf = s33[8];
					SIZE_WORD: nx.cf = s33[16];
					default:   nx.cf = s33[32];
				endcase
				nx.of = |((~(a ^ bb) & (a ^ r)) & sb);
			end
			KIND_SUB, KIND_SBB, KIND_CMP, KIND_DEC: begin
				r     = d33[31:0] & m;
				nx.lo = r;
				nx.cf = {1'b0, a} < ({1'b0, bb} + {32'd0, c});
				nx.of = |(((a ^ bb) & (a ^ r)) & sb);
			end
			KIND_NEG: begin
				r     = (32'd0 - a) & m;
				nx.lo = r;
				nx.cf = (a != 32'd0);
				nx.of = (a == sb);
			end
			KIND_MUL, KIND_IMULW, KIND_IMULT: begin
				nx.hi = prod[63:32];
				nx.lo = prod[31:0];
			end
			KIND_DIV, KIND_IDIV: begin
				nx.hi   = nm[63:32];
				nx.lo   = nm[31:0];
				nx.dm   = dm;
				nx.nneg = nneg;
				nx.dneg = dneg;
				nx.de   = (a == 32'd0) || (nsh >= {32'd0, dm});
			end
			default: begin
				nx.lo = 32'd0;
			end
		endcase
		nx.zf = (r == 32'd0);
		nx.sf = |(r & sb);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= nx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/xalu_div_step.sv -----
// One restoring divider stage: one quotient bit per stage.
`default_nettype none

module xalu_div_step (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  wire                  vld_i,
	input  wire xalu_pkg::pipe_t st_i,
	output logic                 vld_s1,
	output xalu_pkg::pipe_t      st_s1
);
	import xalu_pkg::*;

	xalu_pkg::pipe_t nx;

	// Shift in the next dividend bit and subtract when it fits
	always_comb begin
		logic [32:0] t, diff;
		logic        ge;
		t    = {st_i.hi, st_i.lo[31]};
		diff = t - {1'b0, st_i.dm};
		ge   = (t >= {1'b0, st_i.dm});
		nx   = st_i;
		if ((st_i.kind inside {KIND_DIV, KIND_IDIV}) && !st_i.de) begin
			nx.hi = ge ? diff[31:0] : t[31:0];
			nx.lo = {st_i.lo[30:0], ge};
		end
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= nx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/xalu_back.sv -----
// Final stage: product flags, quotient sign fix-up and output register.
`default_nettype none

module xalu_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  wire                  vld_i,
	input  wire xalu_pkg::pipe_t st_i,
	output logic                 out_valid,
	output xalu_pkg::out_t       out_data
);
	import xalu_pkg::*;

	xalu_pkg::out_t nx;
	logic           vld_q;
	xalu_pkg::out_t res_q;

	// Form the result word
	always_comb begin
		logic [31:0] m, sb, hw, r, q;
		logic [63:0] p, rx;
		logic        qneg, err;
		m  = width_mask(st_i.size_code);
		sb = sign_bit(st_i.size_code);
		p  = {st_i.hi, st_i.lo};
		case (st_i.size_code)
			SIZE_BYTE: hw = {24'd0, st_i.lo[15:8]};
			SIZE_WORD: hw = {16'd0, st_i.lo[31:16]};
			default:   hw = st_i.hi;
		endcase
		r    = st_i.lo & m;
		rx   = (|(r & sb)) ? {32'hffff_ffff, r | ~m} : {32'd0, r};
		qneg = st_i.nneg ^ st_i.dneg;
		err  = st_i.de || (qneg ? (st_i.lo > sb) : (st_i.lo > (sb - 32'd1)));
		q    = qneg ? (32'd0 - st_i.lo) : st_i.lo;
		nx   = '0;
		case (st_i.kind)
			KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBB, KIND_CMP,
			KIND_INC, KIND_DEC, KIND_NEG: begin
				nx.result_low    = st_i.lo;
				nx.write_result  = (st_i.kind != KIND_CMP);
				nx.carry_flag    = st_i.cf;
				nx.overflow_flag = st_i.of;
				nx.zero_flag     = st_i.zf;
				nx.sign_flag     = st_i.sf;
				nx.flags_written = (st_i.kind == KIND_INC || st_i.kind == KIND_DEC) ?
					FW_NO_CF : FW_ALL;
			end
			KIND_MUL: begin
				nx.result_low    = r;
				nx.result_high   = hw;
				nx.write_result  = 1'b1;
				nx.carry_flag    = (hw != 32'd0);
				nx.overflow_flag = (hw != 32'd0);
				nx.flags_written = FW_CF_OF;
			end
			KIND_IMULW, KIND_IMULT: begin
				nx.result_low    = r;
				nx.result_high   = (st_i.kind == KIND_IMULW) ? hw : 32'd0;
				nx.write_result  = 1'b1;
				nx.carry_flag    = (rx != p);
				nx.overflow_flag = (rx != p);
				nx.flags_written = FW_CF_OF;
			end
			KIND_DIV: begin
				if (st_i.de) begin
					nx.divide_error = 1'b1;
				end else begin
					nx.result_low   = st_i.lo;
					nx.result_high  = st_i.hi;
					nx.write_result = 1'b1;
				end
			end
			KIND_IDIV: begin
				if (err) begin
					nx.divide_error = 1'b1;
				end else begin
					nx.result_low   = q & m;
					nx.result_high  = (st_i.nneg ? (32'd0 - st_i.hi) : st_i.hi) & m;
					nx.write_result = 1'b1;
				end
			end
			default: begin
				nx = '0;
			end
		endcase
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= nx;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = res_q;

endmodule

`default_nettype wire
